[sv/etc1_pkg.sv]
// ----------------------------------------------------------------------------
// etc1_pkg
// Shared types, constants and the modifier table for the ETC1 block decoder.
// ----------------------------------------------------------------------------
package etc1_pkg;

  localparam int unsigned WordW      = 32;
  localparam int unsigned ChanW      = 8;
  localparam int unsigned NumChan    = 3;
  localparam int unsigned PixPerBlk  = 16;
  localparam int unsigned PixIdxW    = 4;
  localparam int unsigned CoordW     = 2;
  localparam int unsigned TabW       = 3;
  localparam int unsigned QueueDepthDef = 2;

  // Bit positions inside the color word
  localparam int unsigned FlipBit    = 24;
  localparam int unsigned DiffBit    = 25;
  localparam int unsigned Tab2Lsb    = 26;
  localparam int unsigned Tab1Lsb    = 29;

  // Decoded block, as held between the front and the back
  typedef struct packed {
    logic [NumChan-1:0][ChanW-1:0] base0;     // subblock 1 color, 8 bits/channel
    logic [NumChan-1:0][ChanW-1:0] base1;     // subblock 2 color
    logic [TabW-1:0]               tab0;
    logic [TabW-1:0]               tab1;
    logic                          flip;
    logic [PixPerBlk-1:0]          msb_plane; // indexed by col*4+row
    logic [PixPerBlk-1:0]          lsb_plane;
  } blk_t;

  // Modifier magnitude for table tab; sel picks the large value
  function automatic logic [ChanW-1:0] mod_mag(input logic [TabW-1:0] tab,
                                               input logic            sel);
    logic [ChanW-1:0] small_v;
    logic [ChanW-1:0] large_v;
    case (tab)
      3'd0: begin small_v = 8'd2;  large_v = 8'd8;   end
      3'd1: begin small_v = 8'd5;  large_v = 8'd17;  end
      3'd2: begin small_v = 8'd9;  large_v = 8'd29;  end
      3'd3: begin small_v = 8'd13; large_v = 8'd42;  end
      3'd4: begin small_v = 8'd18; large_v = 8'd60;  end
      3'd5: begin small_v = 8'd24; large_v = 8'd80;  end
      3'd6: begin small_v = 8'd33; large_v = 8'd106; end
      3'd7: begin small_v = 8'd47; large_v = 8'd183; end
      default: begin small_v = '0; large_v = '0; end
    endcase
    return sel ? large_v : small_v;
  endfunction

endpackage

[sv/etc1_front.sv]
// ----------------------------------------------------------------------------
// etc1_front
// Accepts ETC1 blocks, expands base colors and reorders the index planes.
// ----------------------------------------------------------------------------
module etc1_front (
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [etc1_pkg::WordW-1:0] color_word_i,
  input  logic [etc1_pkg::WordW-1:0] index_word_i,
  input  logic                      q_full_i,
  output logic                      q_push_o,
  output etc1_pkg::blk_t            q_data_o
);
  import etc1_pkg::*;

  logic                          diff;
  logic [NumChan-1:0][ChanW-1:0] base0;
  logic [NumChan-1:0][ChanW-1:0] base1;

  // Take a block whenever the queue has room
  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;
  assign diff       = color_word_i[DiffBit];

  // Expand base colors per channel
  always_comb begin
    for (int ch = 0; ch < NumChan; ch++) begin
      logic [ChanW-1:0] byte_v;
      logic [4:0]       base5;
      logic [4:0]       sum5;
      byte_v = color_word_i[ch*ChanW +: ChanW];
      base5  = byte_v[7:3];
      sum5   = base5 + {byte_v[2], byte_v[2], byte_v[2:0]};
      if (diff) begin
        base0[ch] = {base5, base5[4:2]};
        base1[ch] = {sum5, sum5[4:2]};
      end else begin
        base0[ch] = {byte_v[7:4], byte_v[7:4]};
        base1[ch] = {byte_v[3:0], byte_v[3:0]};
      end
    end
  end

  assign q_data_o.base0 = base0;
  assign q_data_o.base1 = base1;

  // Tables, flip and index planes in pixel order
  assign q_data_o.tab0      = color_word_i[Tab1Lsb +: TabW];
  assign q_data_o.tab1      = color_word_i[Tab2Lsb +: TabW];
  assign q_data_o.flip      = color_word_i[FlipBit];
  assign q_data_o.lsb_plane = {index_word_i[23:16], index_word_i[31:24]};
  assign q_data_o.msb_plane = {index_word_i[7:0], index_word_i[15:8]};

endmodule

[sv/etc1_queue.sv]
// ----------------------------------------------------------------------------
// etc1_queue
// Short FIFO of decoded blocks between the front and the back.
// ----------------------------------------------------------------------------
module etc1_queue #(
  parameter int unsigned Depth = etc1_pkg::QueueDepthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  etc1_pkg::blk_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output etc1_pkg::blk_t head_o
);
  import etc1_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  blk_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= FullCnt)
    else $error("queue count exceeds depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push_i && full_o))
    else $error("push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(pop_i && !valid_o))
    else $error("pop from empty queue");

endmodule

[sv/etc1_back.sv]
// ----------------------------------------------------------------------------
// etc1_back
// Walks the 16 pixels of the head block and registers one pixel per cycle while not stalled.
// ----------------------------------------------------------------------------
module etc1_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  etc1_pkg::blk_t              q_head_i,
  output logic                        q_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [etc1_pkg::ChanW-1:0]  pix_red_o,
  output logic [etc1_pkg::ChanW-1:0]  pix_green_o,
  output logic [etc1_pkg::ChanW-1:0]  pix_blue_o,
  output logic [etc1_pkg::CoordW-1:0] pix_col_o,
  output logic [etc1_pkg::CoordW-1:0] pix_row_o,
  output logic                        last_pixel_o
);
  import etc1_pkg::*;

  localparam logic [PixIdxW-1:0] LastIdx = PixIdxW'(PixPerBlk - 1);

  logic [PixIdxW-1:0] k_q;
  logic               out_valid_q;
  logic [NumChan-1:0][ChanW-1:0] pix_q, pix_d;
  logic [CoordW-1:0]  col_q, row_q;
  logic               last_q;

  logic               adv, load;
  logic [CoordW-1:0]  row, col;
  logic [PixIdxW-1:0] p;
  logic               sb, msb, lsb;
  logic [ChanW-1:0]   mag;

  // Output stage moves when empty or when the pixel is taken
  assign adv     = !out_valid_q || out_ready_i;
  assign load    = adv && q_valid_i;
  assign q_pop_o = load && (k_q == LastIdx);

  // Locate the pixel and its modifier
  assign row = k_q[3:2];
  assign col = k_q[1:0];
  assign p   = {col, row};
  assign sb  = q_head_i.flip ? row[1] : col[1];
  assign msb = q_head_i.msb_plane[p];
  assign lsb = q_head_i.lsb_plane[p];
  assign mag = mod_mag(sb ? q_head_i.tab1 : q_head_i.tab0, lsb);

  // Add modifier and clamp each channel
  always_comb begin
    for (int ch = 0; ch < NumChan; ch++) begin
      logic [ChanW-1:0] base_v;
      logic [ChanW:0]   sum_v;
      base_v = sb ? q_head_i.base1[ch] : q_head_i.base0[ch];
      sum_v  = {1'b0, base_v} + {1'b0, mag};
      if (msb) begin
        pix_d[ch] = (base_v < mag) ? '0 : base_v - mag;
      end else begin
        pix_d[ch] = sum_v[ChanW] ? '1 : sum_v[ChanW-1:0];
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_q <= q_valid_i;
      end
      if (load) begin
        k_q <= k_q + 1'b1;
      end
    end
  end

  // Capture pixel payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      pix_q  <= pix_d;
      col_q  <= col;
      row_q  <= row;
      last_q <= (k_q == LastIdx);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pix_red_o    = pix_q[0];
  assign pix_green_o  = pix_q[1];
  assign pix_blue_o   = pix_q[2];
  assign pix_col_o    = col_q;
  assign pix_row_o    = row_q;
  assign last_pixel_o = last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_o |-> (last_pixel_o == (pix_col_o == 2'd3 && pix_row_o == 2'd3)))
    else $error("last mark out of step with coordinates");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   q_pop_o |=> (k_q == '0))
    else $error("pixel counter not back at zero after block");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (adv && !q_valid_i) |=> !out_valid_o)
    else $error("output valid without a loaded pixel");

endmodule

[sv/etc1_block_decoder_core.sv]
// ----------------------------------------------------------------------------
// etc1_block_decoder_core
// ETC1 block decoder: one 64-bit block in, 16 RGB888 pixels out row-major.
// ----------------------------------------------------------------------------
//  Channel | Handshake              | Payload
//  --------+------------------------+-------------------------------------------
//  in      | in_valid_i/in_ready_o  | color_word_i, index_word_i
//  out     | out_valid_o/out_ready_i| pix_red/green/blue, pix_col/row, last_pixel
//
//  The back emits one pixel per cycle while a block is queued and the
//  output is not stalled, from a single pixel counter, which sets the
//  sustained rate. After a block transfer into an idle core the block is
//  registered in the queue, then its first pixel in the output register.
//  The front decodes in the transfer cycle and fills a QueueDepth-entry
//  queue, so new blocks are taken while pixels of earlier ones still drain.
//  A stall on the output holds the pixel register; reset empties the queue.
// ----------------------------------------------------------------------------
module etc1_block_decoder_core #(
  parameter int unsigned QueueDepth = etc1_pkg::QueueDepthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [etc1_pkg::WordW-1:0]  color_word_i,
  input  logic [etc1_pkg::WordW-1:0]  index_word_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [etc1_pkg::ChanW-1:0]  pix_red_o,
  output logic [etc1_pkg::ChanW-1:0]  pix_green_o,
  output logic [etc1_pkg::ChanW-1:0]  pix_blue_o,
  output logic [etc1_pkg::CoordW-1:0] pix_col_o,
  output logic [etc1_pkg::CoordW-1:0] pix_row_o,
  output logic                        last_pixel_o
);
  import etc1_pkg::*;

  logic q_full, q_push, q_pop, q_valid;
  blk_t q_in, q_head;

  etc1_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .color_word_i (color_word_i),
    .index_word_i (index_word_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_data_o     (q_in)
  );

  etc1_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  etc1_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_head_i     (q_head),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pix_red_o    (pix_red_o),
    .pix_green_o  (pix_green_o),
    .pix_blue_o   (pix_blue_o),
    .pix_col_o    (pix_col_o),
    .pix_row_o    (pix_row_o),
    .last_pixel_o (last_pixel_o)
  );

endmodule
